/* rtl/core/im2col_gather_address_top_macros.svh */
// ============================================================================
// im2col gather address - assertion macros
// Short forms for the concurrent checks on the top level ports.
// ============================================================================
`ifndef IM2COL_GATHER_ADDRESS_TOP_MACROS_SVH
`define IM2COL_GATHER_ADDRESS_TOP_MACROS_SVH

// Check a same-cycle implication, clocked on clk, off while in reset
`define I2CGA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, clocked on clk, off while in reset
`define I2CGA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/i2cga_pkg.sv */
// ============================================================================
// i2cga_pkg
// Shared widths, register reset values and register map of the im2col
// gather address generator.
// ============================================================================
package i2cga_pkg;

    // Field widths
    localparam int IDX_W      = 40;
    localparam int SIZE_W     = 11;
    localparam int KSIZE_W    = 4;
    localparam int PAD_W      = 3;

    // Size limits
    localparam int SIZE_MAX   = 1024;
    localparam int KSIZE_CAP  = 15;

    // Parameter defaults
    localparam int ADDR_BITS_DEF  = 40;
    localparam int MAX_KERNEL_DEF = 15;

    // Register port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [SIZE_W-1:0]  CHANNELS_RST    = 11'd1;
    localparam logic [SIZE_W-1:0]  IN_HEIGHT_RST   = 11'd1;
    localparam logic [SIZE_W-1:0]  IN_WIDTH_RST    = 11'd1;
    localparam logic [KSIZE_W-1:0] KERNEL_ROWS_RST = 4'd3;
    localparam logic [KSIZE_W-1:0] KERNEL_COLS_RST = 4'd3;
    localparam logic [PAD_W-1:0]   PADDING_RST     = 3'd1;
    localparam logic [SIZE_W-1:0]  OUT_HEIGHT_RST  = 11'd1;
    localparam logic [SIZE_W-1:0]  OUT_WIDTH_RST   = 11'd1;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_CHANNELS    = 3'd0,
        REG_IN_HEIGHT   = 3'd1,
        REG_IN_WIDTH    = 3'd2,
        REG_KERNEL_ROWS = 3'd3,
        REG_KERNEL_COLS = 3'd4,
        REG_PADDING     = 3'd5,
        REG_OUT_HEIGHT  = 3'd6,
        REG_OUT_WIDTH   = 3'd7
    } cfg_reg_t;

endpackage

/* rtl/core/i2cga_if.sv */
// ============================================================================
// i2cga interfaces
// Valid/ready channels for the index stream and the address result stream.
// ============================================================================
interface i2cga_in_if;
    import i2cga_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] dest_index;
    logic             last_item;

    modport source (output valid, dest_index, last_item, input ready);
    modport sink   (input valid, dest_index, last_item, output ready);
endinterface

interface i2cga_out_if;
    import i2cga_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] dest_out;
    logic [IDX_W-1:0] source_address;
    logic             zero_fill;
    logic             address_overflow;
    logic             last_out;

    modport source (output valid, dest_out, source_address, zero_fill,
                    address_overflow, last_out, input ready);
    modport sink   (input valid, dest_out, source_address, zero_fill,
                    address_overflow, last_out, output ready);
endinterface

/* rtl/core/i2cga_div.sv */
// ============================================================================
// i2cga_div
// Pipelined restoring divider: one quotient bit per stage, with a side
// payload alongside. Hold the divisor static while busy; not enforced here.
// ============================================================================
module i2cga_div #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 21,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  valid_reg;
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  acc_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [DEN_W-1:0]  rem_next [NUM_W];
    logic [NUM_W-1:0]  acc_next [NUM_W];

    // One trial subtraction per stage; the accumulator shifts the dividend
    // out at the top and the quotient in at the bottom
    always_comb
    begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] p_rem;
        logic [NUM_W-1:0] p_acc;
        logic             take;
        for (int k = 0; k < NUM_W; k++)
        begin
            if (k == 0)
            begin
                p_rem = '0;
                p_acc = in_num;
            end
            else
            begin
                p_rem = rem_reg[k-1];
                p_acc = acc_reg[k-1];
            end
            trial       = {p_rem, p_acc[NUM_W-1]};
            take        = (trial >= {1'b0, den});
            rem_next[k] = take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            acc_next[k] = {p_acc[NUM_W-2:0], take};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
        end
    end

    // Advance stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                acc_reg[k] <= acc_next[k];
                if (k == 0)
                begin
                    side_reg[k] <= in_side;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = acc_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

/* rtl/core/im2col_gather_address_top.sv */
// ============================================================================
// im2col_gather_address_top
// Column buffer index to N,C,H,W source address, stride 1, zero padding.
// ============================================================================
// Takes one column buffer index per clock while the skid register is empty,
// and returns one result per index, in order, so indices may follow each
// other with no gap. The path holds 137 register stages: one input stage, 132
// divider stages (one quotient bit each, for the splits by OH*OW, C*R*S, OW,
// S and R), three arithmetic stages and the output register. On the first
// stalled cycle a skid register catches the output register and the input
// stays open for that cycle; the whole pipeline then holds, with the input
// closed, until the skid entry has been taken. Sizes are taken as 1 when
// written as zero and capped at their maxima. Registers sit at byte address
// 4*i; write them only while no index is in flight.
module im2col_gather_address_top #(
    parameter int ADDR_BITS  = i2cga_pkg::ADDR_BITS_DEF,
    parameter int MAX_KERNEL = i2cga_pkg::MAX_KERNEL_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cga_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [i2cga_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [i2cga_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    i2cga_in_if.sink                         idx_in,
    i2cga_out_if.source                      res_out
);
    import i2cga_pkg::*;

    localparam int KMAX  = (MAX_KERNEL < KSIZE_CAP) ? MAX_KERNEL : KSIZE_CAP;
    localparam int SUM_W = 71;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
    } side_a_t;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [19:0]      hw;
    } side_b_t;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] n;
        logic [17:0]      crs;
    } side_c_t;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] n;
        logic [9:0]       h;
        logic [9:0]       w;
    } side_d_t;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] n;
        logic [9:0]       h;
        logic [9:0]       w;
        logic [3:0]       s;
    } side_e_t;

    typedef struct packed {
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] src;
        logic             zf;
        logic             ovf;
        logic             last;
    } res_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(SIZE_MAX))
            r = SIZE_W'(SIZE_MAX);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [KSIZE_W-1:0] clamp_kernel(input logic [KSIZE_W-1:0] v);
        logic [KSIZE_W-1:0] r;
        if (v == '0)
            r = KSIZE_W'(1);
        else if (v > KSIZE_W'(KMAX))
            r = KSIZE_W'(KMAX);
        else
            r = v;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  channels_reg;
    logic [SIZE_W-1:0]  in_height_reg;
    logic [SIZE_W-1:0]  in_width_reg;
    logic [KSIZE_W-1:0] kernel_rows_reg;
    logic [KSIZE_W-1:0] kernel_cols_reg;
    logic [PAD_W-1:0]   padding_reg;
    logic [SIZE_W-1:0]  out_height_reg;
    logic [SIZE_W-1:0]  out_width_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg    <= CHANNELS_RST;
            in_height_reg   <= IN_HEIGHT_RST;
            in_width_reg    <= IN_WIDTH_RST;
            kernel_rows_reg <= KERNEL_ROWS_RST;
            kernel_cols_reg <= KERNEL_COLS_RST;
            padding_reg     <= PADDING_RST;
            out_height_reg  <= OUT_HEIGHT_RST;
            out_width_reg   <= OUT_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_CHANNELS:    channels_reg    <= pwdata[SIZE_W-1:0];
                REG_IN_HEIGHT:   in_height_reg   <= pwdata[SIZE_W-1:0];
                REG_IN_WIDTH:    in_width_reg    <= pwdata[SIZE_W-1:0];
                REG_KERNEL_ROWS: kernel_rows_reg <= pwdata[KSIZE_W-1:0];
                REG_KERNEL_COLS: kernel_cols_reg <= pwdata[KSIZE_W-1:0];
                REG_PADDING:     padding_reg     <= pwdata[PAD_W-1:0];
                REG_OUT_HEIGHT:  out_height_reg  <= pwdata[SIZE_W-1:0];
                REG_OUT_WIDTH:   out_width_reg   <= pwdata[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_sel)
            REG_CHANNELS:    prdata = CFG_DATA_W'(channels_reg);
            REG_IN_HEIGHT:   prdata = CFG_DATA_W'(in_height_reg);
            REG_IN_WIDTH:    prdata = CFG_DATA_W'(in_width_reg);
            REG_KERNEL_ROWS: prdata = CFG_DATA_W'(kernel_rows_reg);
            REG_KERNEL_COLS: prdata = CFG_DATA_W'(kernel_cols_reg);
            REG_PADDING:     prdata = CFG_DATA_W'(padding_reg);
            REG_OUT_HEIGHT:  prdata = CFG_DATA_W'(out_height_reg);
            REG_OUT_WIDTH:   prdata = CFG_DATA_W'(out_width_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes and their products
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  c_c, h_c, w_c, ow_c, oh_c;
    logic [KSIZE_W-1:0] r_c, s_c;
    logic [21:0]        ohw_full;
    logic [14:0]        cr_full;
    logic [17:0]        crs_full;
    logic [21:0]        hwa_full;
    logic [31:0]        chw_full;
    logic [20:0]        hw_size_reg;
    logic [13:0]        cr_reg;
    logic [17:0]        crs_size_reg;
    logic [20:0]        hwa_reg;
    logic [30:0]        chw_reg;

    assign c_c  = clamp_size(channels_reg);
    assign h_c  = clamp_size(in_height_reg);
    assign w_c  = clamp_size(in_width_reg);
    assign oh_c = clamp_size(out_height_reg);
    assign ow_c = clamp_size(out_width_reg);
    assign r_c  = clamp_kernel(kernel_rows_reg);
    assign s_c  = clamp_kernel(kernel_cols_reg);

    assign ohw_full = 22'(oh_c) * 22'(ow_c);
    assign cr_full  = 15'(c_c) * 15'(r_c);
    assign crs_full = 18'(cr_reg) * 18'(s_c);
    assign hwa_full = 22'(h_c) * 22'(w_c);
    assign chw_full = 32'(c_c) * 32'(hwa_reg);

    // Hold the size products, one multiplication per register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_size_reg  <= 21'd1;
            cr_reg       <= 14'd3;
            crs_size_reg <= 18'd9;
            hwa_reg      <= 21'd1;
            chw_reg      <= 31'd1;
        end
        else
        begin
            hw_size_reg  <= ohw_full[20:0];
            cr_reg       <= cr_full[13:0];
            crs_size_reg <= crs_full;
            hwa_reg      <= hwa_full[20:0];
            chw_reg      <= chw_full[30:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable and input stage
    // ------------------------------------------------------------------
    logic             sk_valid_reg;
    logic             en;
    logic             s0_valid_reg;
    logic [IDX_W-1:0] s0_idx_reg;
    logic             s0_last_reg;

    assign en           = ~sk_valid_reg;
    assign idx_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= idx_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_idx_reg  <= idx_in.dest_index;
            s0_last_reg <= idx_in.last_item;
        end
    end

    // ------------------------------------------------------------------
    // Index split: idx / (OH*OW), then by C*R*S, OW, S and R
    // ------------------------------------------------------------------
    side_a_t          a_in_side, a_side;
    logic [$bits(side_a_t)-1:0] a_side_vec;
    logic             a_valid;
    logic [IDX_W-1:0] a_quo;
    logic [20:0]      a_rem;

    assign a_in_side = '{last: s0_last_reg, idx: s0_idx_reg};

    i2cga_div #(.NUM_W(IDX_W), .DEN_W(21), .SIDE_W($bits(side_a_t))) u_div_hw (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s0_valid_reg), .in_num(s0_idx_reg), .den(hw_size_reg),
        .in_side(a_in_side),
        .out_valid(a_valid), .out_quo(a_quo), .out_rem(a_rem), .out_side(a_side_vec)
    );
    assign a_side = side_a_t'(a_side_vec);

    side_b_t          b_in_side, b_side;
    logic [$bits(side_b_t)-1:0] b_side_vec;
    logic             b_valid;
    logic [IDX_W-1:0] b_quo;
    logic [17:0]      b_rem;

    assign b_in_side = '{last: a_side.last, idx: a_side.idx, hw: a_rem[19:0]};

    i2cga_div #(.NUM_W(IDX_W), .DEN_W(18), .SIDE_W($bits(side_b_t))) u_div_crs (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(a_valid), .in_num(a_quo), .den(crs_size_reg),
        .in_side(b_in_side),
        .out_valid(b_valid), .out_quo(b_quo), .out_rem(b_rem), .out_side(b_side_vec)
    );
    assign b_side = side_b_t'(b_side_vec);

    side_c_t          c_in_side, c_side;
    logic [$bits(side_c_t)-1:0] c_side_vec;
    logic             c_valid;
    logic [19:0]      c_quo;
    logic [10:0]      c_rem;

    assign c_in_side = '{last: b_side.last, idx: b_side.idx, n: b_quo, crs: b_rem};

    i2cga_div #(.NUM_W(20), .DEN_W(SIZE_W), .SIDE_W($bits(side_c_t))) u_div_ow (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(b_valid), .in_num(b_side.hw), .den(ow_c),
        .in_side(c_in_side),
        .out_valid(c_valid), .out_quo(c_quo), .out_rem(c_rem), .out_side(c_side_vec)
    );
    assign c_side = side_c_t'(c_side_vec);

    side_d_t          d_in_side, d_side;
    logic [$bits(side_d_t)-1:0] d_side_vec;
    logic             d_valid;
    logic [17:0]      d_quo;
    logic [3:0]       d_rem;

    assign d_in_side = '{last: c_side.last, idx: c_side.idx, n: c_side.n,
                         h: c_quo[9:0], w: c_rem[9:0]};

    i2cga_div #(.NUM_W(18), .DEN_W(KSIZE_W), .SIDE_W($bits(side_d_t))) u_div_s (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c_valid), .in_num(c_side.crs), .den(s_c),
        .in_side(d_in_side),
        .out_valid(d_valid), .out_quo(d_quo), .out_rem(d_rem), .out_side(d_side_vec)
    );
    assign d_side = side_d_t'(d_side_vec);

    side_e_t          e_in_side, e_side;
    logic [$bits(side_e_t)-1:0] e_side_vec;
    logic             e_valid;
    logic [13:0]      e_quo;
    logic [3:0]       e_rem;

    assign e_in_side = '{last: d_side.last, idx: d_side.idx, n: d_side.n,
                         h: d_side.h, w: d_side.w, s: d_rem};

    i2cga_div #(.NUM_W(14), .DEN_W(KSIZE_W), .SIDE_W($bits(side_e_t))) u_div_r (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d_valid), .in_num(d_quo[13:0]), .den(r_c),
        .in_side(e_in_side),
        .out_valid(e_valid), .out_quo(e_quo), .out_rem(e_rem), .out_side(e_side_vec)
    );
    assign e_side = side_e_t'(e_side_vec);

    // ------------------------------------------------------------------
    // Stage F1: padding test and input pixel position
    // ------------------------------------------------------------------
    logic [10:0]      ihp, iwp, h_lim, w_lim, ih_full, iw_full;
    logic             in_image;
    logic             f1_valid_reg;
    logic             f1_last_reg;
    logic [IDX_W-1:0] f1_idx_reg;
    logic [IDX_W-1:0] f1_n_reg;
    logic [9:0]       f1_c_reg, f1_ih_reg, f1_iw_reg;
    logic             f1_zf_reg;

    assign ihp      = 11'(e_side.h) + 11'(e_rem);
    assign iwp      = 11'(e_side.w) + 11'(e_side.s);
    assign h_lim    = h_c + 11'(padding_reg);
    assign w_lim    = w_c + 11'(padding_reg);
    assign in_image = (ihp >= 11'(padding_reg)) && (ihp < h_lim) &&
                      (iwp >= 11'(padding_reg)) && (iwp < w_lim);
    assign ih_full  = ihp - 11'(padding_reg);
    assign iw_full  = iwp - 11'(padding_reg);

    // ------------------------------------------------------------------
    // Stage F2: partial products
    // ------------------------------------------------------------------
    logic [30:0]      mc_next;
    logic [20:0]      mi_next;
    logic [50:0]      plo_next, phi_next;
    logic             f2_valid_reg;
    logic             f2_last_reg;
    logic [IDX_W-1:0] f2_idx_reg;
    logic [9:0]       f2_iw_reg;
    logic             f2_zf_reg;
    logic [30:0]      f2_mc_reg;
    logic [20:0]      f2_mi_reg;
    logic [50:0]      f2_plo_reg, f2_phi_reg;

    assign mc_next  = 31'(f1_c_reg) * 31'(hwa_reg);
    assign mi_next  = 21'(f1_ih_reg) * 21'(w_c);
    assign plo_next = 51'(f1_n_reg[19:0]) * 51'(chw_reg);
    assign phi_next = 51'(f1_n_reg[39:20]) * 51'(chw_reg);

    // ------------------------------------------------------------------
    // Stage F3: offset within the sample and sample base
    // ------------------------------------------------------------------
    logic [30:0]      base_next;
    logic [SUM_W-1:0] psum_next;
    logic             f3_valid_reg;
    logic             f3_last_reg;
    logic [IDX_W-1:0] f3_idx_reg;
    logic             f3_zf_reg;
    logic [30:0]      f3_base_reg;
    logic [SUM_W-1:0] f3_psum_reg;

    assign base_next = f2_mc_reg + 31'(f2_mi_reg) + 31'(f2_iw_reg);
    assign psum_next = {20'd0, f2_plo_reg} + {f2_phi_reg, 20'd0};

    // ------------------------------------------------------------------
    // Stage F4: full address, range check, result
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] total;
    logic             ovf;
    res_t             res_next;
    logic             p_valid_reg;
    res_t             p_reg;
    res_t             sk_reg;

    assign total = f3_psum_reg + {40'd0, f3_base_reg};
    assign ovf   = ~f3_zf_reg && ((total >> ADDR_BITS) != '0);

    always_comb
    begin
        res_next.dest = f3_idx_reg;
        res_next.src  = (f3_zf_reg || ovf) ? '0 : total[IDX_W-1:0];
        res_next.zf   = f3_zf_reg;
        res_next.ovf  = ovf;
        res_next.last = f3_last_reg;
    end

    // Advance F stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= e_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            p_valid_reg  <= f3_valid_reg;
        end
    end

    // Advance F stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_last_reg <= e_side.last;
            f1_idx_reg  <= e_side.idx;
            f1_n_reg    <= e_side.n;
            f1_c_reg    <= e_quo[9:0];
            f1_ih_reg   <= ih_full[9:0];
            f1_iw_reg   <= iw_full[9:0];
            f1_zf_reg   <= ~in_image;

            f2_last_reg <= f1_last_reg;
            f2_idx_reg  <= f1_idx_reg;
            f2_iw_reg   <= f1_iw_reg;
            f2_zf_reg   <= f1_zf_reg;
            f2_mc_reg   <= mc_next;
            f2_mi_reg   <= mi_next;
            f2_plo_reg  <= plo_next;
            f2_phi_reg  <= phi_next;

            f3_last_reg <= f2_last_reg;
            f3_idx_reg  <= f2_idx_reg;
            f3_zf_reg   <= f2_zf_reg;
            f3_base_reg <= base_next;
            f3_psum_reg <= psum_next;

            p_reg       <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Skid stage: catch the output register when the sink stalls
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_valid_reg <= 1'b0;
        end
        else if (sk_valid_reg)
        begin
            if (res_out.ready)
                sk_valid_reg <= 1'b0;
        end
        else if (p_valid_reg && !res_out.ready)
        begin
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sk_valid_reg && p_valid_reg && !res_out.ready)
            sk_reg <= p_reg;
    end

    // Present the oldest result
    assign res_out.valid            = sk_valid_reg | p_valid_reg;
    assign res_out.dest_out         = sk_valid_reg ? sk_reg.dest : p_reg.dest;
    assign res_out.source_address   = sk_valid_reg ? sk_reg.src  : p_reg.src;
    assign res_out.zero_fill        = sk_valid_reg ? sk_reg.zf   : p_reg.zf;
    assign res_out.address_overflow = sk_valid_reg ? sk_reg.ovf  : p_reg.ovf;
    assign res_out.last_out         = sk_valid_reg ? sk_reg.last : p_reg.last;

endmodule

/* rtl/core/i2cga_chk.sv */
// ============================================================================
// i2cga_chk
// Port-level checks on the gather address generator, bound to the top level.
// ============================================================================
module i2cga_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [i2cga_pkg::IDX_W-1:0] dest_out,
    input logic [i2cga_pkg::IDX_W-1:0] src,
    input logic                        zero_fill,
    input logic                        address_overflow,
    input logic                        last_out
);
    `include "im2col_gather_address_top_macros.svh"

    // Input side stays open while no result is pending
    `I2CGA_ASSERT_IMPL(a_open_when_empty, !out_valid, in_ready, "input stalled with empty output")

    // Padding pixel: no overflow and a zero address
    `I2CGA_ASSERT_IMPL(a_fill_clean, out_valid && zero_fill, !address_overflow && (src == '0), "padding result not clean")

    // Overflow: zero address
    `I2CGA_ASSERT_IMPL(a_ovf_zero, out_valid && address_overflow, src == '0, "overflow result carries an address")

    // Stalled transaction holds
    `I2CGA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(src) && $stable(dest_out) && $stable(zero_fill) && $stable(address_overflow) && $stable(last_out), "stalled result changed")

endmodule

bind im2col_gather_address_top i2cga_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (idx_in.ready),
    .out_valid        (res_out.valid),
    .out_ready        (res_out.ready),
    .dest_out         (res_out.dest_out),
    .src              (res_out.source_address),
    .zero_fill        (res_out.zero_fill),
    .address_overflow (res_out.address_overflow),
    .last_out         (res_out.last_out)
);

/* sim/tb_im2col_gather_address_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_im2col_gather_address_top
// Self-checking bench for the im2col gather address generator.
// ============================================================================
// Each phase programs the size registers over the APB port while the block
// is idle. It then streams column buffer indices through the valid/ready
// input. A local gather address predictor checks every result in order.
// Phases cover reset values, zero and over-range sizes, the largest sizes
// and a large-tensor setting that reaches the address overflow flag.
module tb_im2col_gather_address_top;
    import i2cga_pkg::*;

    localparam int  DRAIN_CYCLES = 160;
    localparam int  STALL_LIMIT  = 3000;
    localparam longint unsigned IDX_MASK = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [IDX_W-1:0] dest_out;
        logic [IDX_W-1:0] source_address;
        logic             zero_fill;
        logic             address_overflow;
        logic             last_out;
    } gather_t;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic             last_item;
    } index_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    i2cga_in_if  idx_if ();
    i2cga_out_if res_if ();

    im2col_gather_address_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .idx_in  (idx_if.sink),
        .res_out (res_if.source)
    );

    // Register copy held by the bench, at register width
    logic [SIZE_W-1:0] size_regs [8];

    index_t  pending_idx [$];
    gather_t expected_res [$];
    int      mismatches;
    int      quiet_cycles;
    bit      idx_taken;
    int      send_gap;
    int      recv_gap;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned size_eff(longint unsigned v, longint unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Split the index and form the N,C,H,W source address
    function automatic gather_t gather_predict(logic [IDX_W-1:0] idx, logic lst);
        longint unsigned ch, ih_sz, iw_sz, kr, kc, pad, oh, ow;
        longint unsigned hw_sz, crs_sz, hw, rest, crs, n, w, h, s, r, c;
        longint unsigned ih_p, iw_p, chw, base, lim;
        gather_t g;
        ch    = size_eff(size_regs[REG_CHANNELS], SIZE_MAX);
        ih_sz = size_eff(size_regs[REG_IN_HEIGHT], SIZE_MAX);
        iw_sz = size_eff(size_regs[REG_IN_WIDTH], SIZE_MAX);
        kr    = size_eff(size_regs[REG_KERNEL_ROWS], KSIZE_CAP);
        kc    = size_eff(size_regs[REG_KERNEL_COLS], KSIZE_CAP);
        pad   = size_regs[REG_PADDING] & 7;
        oh    = size_eff(size_regs[REG_OUT_HEIGHT], SIZE_MAX);
        ow    = size_eff(size_regs[REG_OUT_WIDTH], SIZE_MAX);
        hw_sz  = oh * ow;
        crs_sz = ch * kr * kc;
        hw   = idx % hw_sz;
        rest = idx / hw_sz;
        crs  = rest % crs_sz;
        n    = rest / crs_sz;
        w = hw % ow;
        h = hw / ow;
        s = crs % kc;
        r = (crs / kc) % kr;
        c = crs / (kr * kc);
        ih_p = h + r;
        iw_p = w + s;
        g = '0;
        g.dest_out = idx;
        g.last_out = lst;
        if (ih_p >= pad && ih_p < pad + ih_sz && iw_p >= pad && iw_p < pad + iw_sz)
        begin
            chw  = ch * ih_sz * iw_sz;
            base = c * ih_sz * iw_sz + (ih_p - pad) * iw_sz + (iw_p - pad);
            lim  = IDX_MASK;
            if (base > lim || n > (lim - base) / chw)
                g.address_overflow = 1'b1;
            else
                g.source_address = IDX_W'(n * chw + base);
        end
        else
            g.zero_fill = 1'b1;
        return g;
    endfunction

    // Build an index from chosen sample, kernel and pixel coordinates, or a random 40-bit index
    function automatic logic [IDX_W-1:0] compose_index();
        longint unsigned hw_sz, crs_sz, n, sum;
        hw_sz  = size_eff(size_regs[REG_OUT_HEIGHT], SIZE_MAX)
               * size_eff(size_regs[REG_OUT_WIDTH], SIZE_MAX);
        crs_sz = size_eff(size_regs[REG_CHANNELS], SIZE_MAX)
               * size_eff(size_regs[REG_KERNEL_ROWS], KSIZE_CAP)
               * size_eff(size_regs[REG_KERNEL_COLS], KSIZE_CAP);
        case ($urandom_range(0, 9))
            0:       return IDX_W'({$urandom, $urandom} & IDX_MASK);
            1:       n = (IDX_MASK / (hw_sz * crs_sz)) - $urandom_range(0, 3);
            2, 3:    n = $urandom % ((IDX_MASK / (hw_sz * crs_sz)) + 1);
            default: n = $urandom_range(0, 3);
        endcase
        sum = (n * crs_sz + $urandom % crs_sz) * hw_sz + $urandom % hw_sz;
        return IDX_W'(sum & IDX_MASK);
    endfunction

    task automatic push_index(logic [IDX_W-1:0] idx, logic lst);
        index_t t;
        t.dest_index = idx;
        t.last_item  = lst;
        pending_idx.push_back(t);
    endtask

    // One APB write: setup then access, mirrored into the local copy
    task automatic apb_write(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'(4 * int'(which));
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (which)
            REG_KERNEL_ROWS, REG_KERNEL_COLS:
                size_regs[which] = SIZE_W'(value[KSIZE_W-1:0]);
            REG_PADDING:
                size_regs[which] = SIZE_W'(value[PAD_W-1:0]);
            default:
                size_regs[which] = value[SIZE_W-1:0];
        endcase
    endtask

    // Hold until the input queue is empty and every result has come back
    task automatic wait_idle();
        while (pending_idx.size() != 0 || idx_if.valid || expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int c, int ih, int iw, int kr, int kc, int pad, int oh, int ow);
        wait_idle();
        apb_write(REG_CHANNELS, c);
        apb_write(REG_IN_HEIGHT, ih);
        apb_write(REG_IN_WIDTH, iw);
        apb_write(REG_KERNEL_ROWS, kr);
        apb_write(REG_KERNEL_COLS, kc);
        apb_write(REG_PADDING, pad);
        apb_write(REG_OUT_HEIGHT, oh);
        apb_write(REG_OUT_WIDTH, ow);
    endtask

    task automatic random_batch(int count);
        for (int i = 0; i < count; i++)
            push_index(compose_index(), (i == count - 1) || ($urandom_range(0, 15) == 0));
    endtask

    // Driver: present the next index at the falling edge
    always @(negedge clk)
    begin
        index_t t;
        if (!rst_n)
        begin
            idx_if.valid <= 1'b0;
            send_gap     <= 0;
        end
        else if (!idx_if.valid || idx_taken)
        begin
            if (send_gap > 0 || pending_idx.size() == 0)
            begin
                idx_if.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                t = pending_idx.pop_front();
                idx_if.valid      <= 1'b1;
                idx_if.dest_index <= t.dest_index;
                idx_if.last_item  <= t.last_item;
                case ($urandom_range(0, 19))
                    0:          send_gap <= $urandom_range(10, 40);
                    1, 2, 3, 4: send_gap <= $urandom_range(1, 3);
                    default:    send_gap <= 0;
                endcase
            end
        end
    end

    // Result back-pressure: mostly short stalls, a few long ones
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_gap     <= 0;
        end
        else if (recv_gap > 0)
        begin
            res_if.ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
        end
        else
        begin
            res_if.ready <= 1'b1;
            case ($urandom_range(0, 29))
                0:             recv_gap <= $urandom_range(10, 50);
                1, 2, 3, 4, 5: recv_gap <= $urandom_range(1, 3);
                default:       recv_gap <= 0;
            endcase
        end
    end

    // Monitor: predict on each accepted index, check each accepted result
    always @(posedge clk)
    begin
        gather_t got;
        gather_t exp_r;
        if (rst_n)
        begin
            idx_taken = idx_if.valid && idx_if.ready;
            if (idx_taken)
                expected_res.push_back(gather_predict(idx_if.dest_index, idx_if.last_item));
            if (res_if.valid && res_if.ready)
            begin
                got.dest_out         = res_if.dest_out;
                got.source_address   = res_if.source_address;
                got.zero_fill        = res_if.zero_fill;
                got.address_overflow = res_if.address_overflow;
                got.last_out         = res_if.last_out;
                if (expected_res.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result transaction %h", $realtime, got);
                end
                else
                begin
                    exp_r = expected_res.pop_front();
                    if (got.dest_out !== exp_r.dest_out)
                    begin
                        mismatches++;
                        $display("%0t: dest_out expected %h actual %h",
                                 $realtime, exp_r.dest_out, got.dest_out);
                    end
                    if (got.source_address !== exp_r.source_address)
                    begin
                        mismatches++;
                        $display("%0t: source_address expected %h actual %h (dest %h)",
                                 $realtime, exp_r.source_address, got.source_address,
                                 exp_r.dest_out);
                    end
                    if (got.zero_fill !== exp_r.zero_fill)
                    begin
                        mismatches++;
                        $display("%0t: zero_fill expected %b actual %b (dest %h)",
                                 $realtime, exp_r.zero_fill, got.zero_fill, exp_r.dest_out);
                    end
                    if (got.address_overflow !== exp_r.address_overflow)
                    begin
                        mismatches++;
                        $display("%0t: address_overflow expected %b actual %b (dest %h)",
                                 $realtime, exp_r.address_overflow, got.address_overflow,
                                 exp_r.dest_out);
                    end
                    if (got.last_out !== exp_r.last_out)
                    begin
                        mismatches++;
                        $display("%0t: last_out expected %b actual %b (dest %h)",
                                 $realtime, exp_r.last_out, got.last_out, exp_r.dest_out);
                    end
                end
            end
            // Watchdog on cycles with no transaction on either side or the APB port
            if (idx_taken || (res_if.valid && res_if.ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        idx_if.valid      = 1'b0;
        idx_if.dest_index = '0;
        idx_if.last_item  = 1'b0;
        res_if.ready      = 1'b0;
        idx_taken         = 1'b0;
        mismatches        = 0;
        quiet_cycles      = 0;
        size_regs[REG_CHANNELS]    = CHANNELS_RST;
        size_regs[REG_IN_HEIGHT]   = IN_HEIGHT_RST;
        size_regs[REG_IN_WIDTH]    = IN_WIDTH_RST;
        size_regs[REG_KERNEL_ROWS] = SIZE_W'(KERNEL_ROWS_RST);
        size_regs[REG_KERNEL_COLS] = SIZE_W'(KERNEL_COLS_RST);
        size_regs[REG_PADDING]     = SIZE_W'(PADDING_RST);
        size_regs[REG_OUT_HEIGHT]  = OUT_HEIGHT_RST;
        size_regs[REG_OUT_WIDTH]   = OUT_WIDTH_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset sizes, index extremes, every kernel tap, last flag
        push_index('0, 1'b0);
        push_index(IDX_W'(IDX_MASK), 1'b1);
        push_index(40'hAA_AAAA_AAAA, 1'b0);
        push_index(40'h55_5555_5555, 1'b1);
        for (int i = 0; i < 9; i++)
            push_index(IDX_W'(i), i == 8);
        push_index(IDX_W'(9), 1'b0);

        // Directed: a small padded image, then over-range and zero sizes
        configure(2, 3, 3, 3, 3, 1, 3, 3);
        for (int i = 0; i < 6; i++)
            push_index(IDX_W'(i * 13), i == 5);
        configure(0, 2047, 0, 0, 15, 0, 0, 2047);
        push_index('0, 1'b0);
        push_index(IDX_W'(IDX_MASK), 1'b1);
        random_batch(60);

        // Largest sizes and padding
        configure(1024, 1024, 1024, 15, 15, 7, 1024, 1024);
        push_index('0, 1'b0);
        push_index(IDX_W'(IDX_MASK), 1'b1);
        random_batch(90);

        // Large tensor with a 1x1 kernel: sample index reaches overflow
        configure(1024, 1024, 1024, 1, 1, 0, 1, 1);
        push_index(40'h40_0000_0000, 1'b0);
        push_index(40'h3F_FFFF_FFFF, 1'b0);
        push_index(IDX_W'(IDX_MASK), 1'b1);
        random_batch(100);

        // Small shapes where padding dominates
        configure(3, 4, 5, 5, 3, 3, 6, 4);
        random_batch(120);
        configure(1, 1, 1, 15, 15, 7, 2, 2);
        random_batch(60);

        // Random settings, including zero sizes
        for (int p = 0; p < 5; p++)
        begin
            configure($urandom_range(0, 64), $urandom_range(0, 40), $urandom_range(0, 40),
                      $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                      $urandom_range(0, 40), $urandom_range(0, 40));
            random_batch(80);
        end

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
